/* hw/rtl/irm_pkg.sv */
// ----------------------------------------------------------------------------
// irm_pkg: shared types and constants for the insertable range minimum
//
// Word formats of the request and response channels, the status and
// command codes, and the word that travels along the chain of cells
// while a range minimum is worked out.
// ----------------------------------------------------------------------------
package irm_pkg;

    // Default number of cells in the chain.
    localparam int CAPACITY_DEFAULT = 1024;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    // Status codes of a response word.
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_ANSWERED = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_BADPOS   = 3'd4;

    // Request word.
    typedef struct packed {
        logic               cmd;
        logic [10:0]        insert_position;
        logic signed [31:0] insert_value;
        logic [9:0]         query_first;
        logic [9:0]         query_last;
    } req_word_t;

    // Response word.
    typedef struct packed {
        logic signed [31:0] min_value;
        logic [2:0]         status;
    } rsp_word_t;

    // Running minimum handed from one cell to the next.
    typedef struct packed {
        logic               found;
        logic signed [31:0] min_value;
    } chain_t;

endpackage

/* hw/rtl/irm_cell.sv */
// ----------------------------------------------------------------------------
// irm_cell: one storage cell of the insertable range minimum
//
// Holds the value at one fixed index of the sequence. On an insert the
// cell takes its left neighbour's value, the new value, or keeps its own.
// Every cycle it folds its own value into the running minimum coming from
// the left when its index lies inside the query range, and registers it.
// ----------------------------------------------------------------------------
module irm_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 11
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  logic [CW-1:0]      pos,
    input  logic signed [31:0] new_value,
    input  logic signed [31:0] left_value,
    output logic signed [31:0] value,
    input  logic [CW-1:0]      first,
    input  logic [CW-1:0]      last,
    input  irm_pkg::chain_t    chain_in,
    output irm_pkg::chain_t    chain_out
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    irm_pkg::chain_t    chain_reg;
    irm_pkg::chain_t    chain_next;
    logic               in_range;

    // Insert: cells above the position move up, the cell at it takes the word.
    always_comb
    begin
        value_next = value_reg;
        if (shift_en)
        begin
            if (IDX > pos)
            begin
                value_next = left_value;
            end
            else if (IDX == pos)
            begin
                value_next = new_value;
            end
        end
    end

    // Running minimum over the cells inside the range.
    assign in_range = (IDX >= first) && (IDX <= last);

    always_comb
    begin
        chain_next = chain_in;
        if (in_range)
        begin
            chain_next.found = 1'b1;
            if (!chain_in.found || (value_reg < chain_in.min_value))
            begin
                chain_next.min_value = value_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
            chain_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
            chain_reg <= chain_next;
        end
    end

    assign value     = value_reg;
    assign chain_out = chain_reg;

endmodule

/* hw/rtl/insertable_range_minimum.sv */
// ----------------------------------------------------------------------------
// insertable_range_minimum: ordered sequence with insert and range minimum
//
// Requests arrive on req (valid/stall); each gives exactly one response
// word on rsp (valid/stall), in request order.
// An insert places a value at a position and moves later values up by
// one; every cell shifts in the same cycle. Its response passes through
// the holding register and then the output register, and no new request
// is taken while it waits in the holding register. A query sends a
// running minimum down the chain of CAPACITY cells, one cell per cycle;
// the sequencer waits in S_QUERY while it travels, then S_FINISH hands
// the minimum to the holding register, and no request is taken in between.
// A query whose clipped range is empty answers from the idle state like an insert.
// One request is worked on at a time. A finished response waits in a
// holding register while the output register is stalled, so one more
// request can be taken; after that req_stall stays high until rsp moves.
// After reset the sequence holds a single zero and both channels are idle.
// ----------------------------------------------------------------------------
module insertable_range_minimum #(
    parameter int CAPACITY = irm_pkg::CAPACITY_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  irm_pkg::req_word_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output irm_pkg::rsp_word_t  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CW    = (CNT_W > 11) ? CNT_W : 11;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_QUERY  = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    wait_reg;
    logic [IDX_W-1:0]    wait_next;
    logic [CW-1:0]       first_reg;
    logic [CW-1:0]       first_next;
    logic [CW-1:0]       last_reg;
    logic [CW-1:0]       last_next;
    logic                pend_valid_reg;
    logic                pend_valid_next;
    irm_pkg::rsp_word_t  pend_reg;
    irm_pkg::rsp_word_t  pend_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    irm_pkg::rsp_word_t  rsp_reg;
    irm_pkg::rsp_word_t  rsp_next;

    logic                accept;
    logic                out_free;
    logic                full;
    logic                bad_pos;
    logic                shift_en;
    logic                empty;
    logic [CW-1:0]       pos_ext;
    logic [CW-1:0]       cnt_ext;
    logic [CW-1:0]       cnt_m1;
    logic [CW-1:0]       first_ext;
    logic [CW-1:0]       last_ext;
    logic [CW-1:0]       last_clip;
    logic                produce;
    irm_pkg::rsp_word_t  result;

    logic signed [31:0]  cell_value [CAPACITY];
    logic signed [31:0]  left_value [CAPACITY];
    irm_pkg::chain_t     chain      [CAPACITY+1];

    // Handshake: take a word only when idle and the holding register is free.
    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE) || pend_valid_reg;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Request decode and checks against the current length.
    assign pos_ext   = CW'(req.insert_position);
    assign cnt_ext   = CW'(count_reg);
    assign cnt_m1    = CW'(count_reg - CNT_W'(1));
    assign first_ext = CW'(req.query_first);
    assign last_ext  = CW'(req.query_last);
    assign last_clip = (last_ext > cnt_m1) ? cnt_m1 : last_ext;
    assign empty     = first_ext > last_clip;
    assign full      = count_reg == CNT_W'(CAPACITY);
    assign bad_pos   = pos_ext > cnt_ext;
    assign shift_en  = accept && (req.cmd == irm_pkg::CMD_INSERT) && !full && !bad_pos;

    // Sequencer and result selection.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        wait_next  = wait_reg;
        first_next = first_reg;
        last_next  = last_reg;
        produce    = 1'b0;
        result     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    produce = 1'b1;
                    if (req.cmd == irm_pkg::CMD_INSERT)
                    begin
                        if (full)
                        begin
                            result.status = irm_pkg::ST_FULL;
                        end
                        else if (bad_pos)
                        begin
                            result.status = irm_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            result.status = irm_pkg::ST_INSERTED;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end
                    else if (empty)
                    begin
                        result.status = irm_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        produce    = 1'b0;
                        first_next = first_ext;
                        last_next  = last_clip;
                        wait_next  = '0;
                        state_next = S_QUERY;
                    end
                end
            end
            S_QUERY:
            begin
                wait_next = wait_reg + IDX_W'(1);
                if (wait_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                produce          = 1'b1;
                result.status    = irm_pkg::ST_ANSWERED;
                result.min_value = chain[CAPACITY].min_value;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Holding register and output register.
    always_comb
    begin
        pend_valid_next = (pend_valid_reg && !out_free) || produce;
        pend_next       = produce ? result : pend_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        if (out_free)
        begin
            rsp_valid_next = pend_valid_reg;
            rsp_next       = pend_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= CNT_W'(1);
            wait_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            wait_reg       <= wait_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        last_reg  <= last_next;
        pend_reg  <= pend_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Chain of cells; the running minimum enters empty at the front.
    assign chain[0] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_front
            assign left_value[i] = req.insert_value;
        end
        else
        begin : g_rest
            assign left_value[i] = cell_value[i-1];
        end

        irm_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (shift_en),
            .pos        (pos_ext),
            .new_value  (req.insert_value),
            .left_value (left_value[i]),
            .value      (cell_value[i]),
            .first      (first_reg),
            .last       (last_reg),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1])
        );
    end

endmodule
